FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DNA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DNA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dna_pkg.sv
// Package with the types, codes and defaults of the descriptor number allocator.
package dna_pkg;

	localparam int DNA_NUM_IDS        = 256;
	localparam int DNA_SCAN_WORD_BITS = 16;

	localparam logic [1:0] DNA_MODE_GET   = 2'd0;
	localparam logic [1:0] DNA_MODE_CLAIM = 2'd1;
	localparam logic [1:0] DNA_MODE_FREE  = 2'd2;

	localparam logic [1:0] DNA_ST_OK    = 2'd0;
	localparam logic [1:0] DNA_ST_FULL  = 2'd1;
	localparam logic [1:0] DNA_ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] fd_number;
	} dna_req_t;

	typedef struct packed {
		logic [7:0] granted_number;
		logic [1:0] status;
	} dna_rsp_t;

	typedef struct packed {
		logic hit;
		logic last;
		logic found;
	} dna_scan_flags_t;

endpackage

FILE: rtl/descriptor_number_allocator.sv
// Descriptor number allocator: bitmap of used numbers walked one word per cycle.
// Get scans from the hint word for a free number below the high mark, else takes the high mark or reports full.
// Claim and free walk from word 0 to the number's word; bad requests are answered from idle.
// One item at a time: the single read port of the memory and the shared compare unit set the pace.
// After reset a clearing pass writes every bitmap word to zero and
// holds busy high. Each result is shown for one cycle on done; the receiver cannot stall.
`include "assert_macros.svh"

module descriptor_number_allocator import dna_pkg::*; #(
	parameter int NUM_IDS        = DNA_NUM_IDS,
	parameter int SCAN_WORD_BITS = DNA_SCAN_WORD_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dna_req_t req,
	output logic     done,
	output dna_rsp_t rsp
);

	localparam int W         = SCAN_WORD_BITS;
	localparam int NUM_WORDS = (NUM_IDS + W - 1) / W;
	localparam int AddrW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int OffW      = (W > 1) ? $clog2(W) : 1;
	localparam int ValW      = $clog2(NUM_WORDS * W + 1);

	localparam logic [AddrW-1:0] LastWord = AddrW'(NUM_WORDS - 1);
	localparam logic [OffW-1:0]  LastOff  = OffW'(W - 1);
	localparam logic [ValW-1:0]  NumIds   = ValW'(NUM_IDS);
	localparam logic [ValW-1:0]  WordStep = ValW'(W);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOCATE,
		S_SCAN,
		S_MARK,
		S_RMW_RD,
		S_RMW_WR
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic              mark_q;
	logic [ValW-1:0]   num_q;
	logic [AddrW-1:0]  word_q;
	logic [ValW-1:0]   base_q;
	logic              chk_vld_s1;
	logic [AddrW-1:0]  chk_word_s1;
	logic [ValW-1:0]   chk_base_s1;
	logic [AddrW-1:0]  tgt_word_q;
	logic [ValW-1:0]   tgt_base_q;
	logic [OffW-1:0]   tgt_off_q;
	logic [ValW-1:0]   tgt_id_q;
	logic [ValW-1:0]   high_mark_q;
	logic [AddrW-1:0]  hm_word_q;
	logic [OffW-1:0]   hm_off_q;
	logic [ValW-1:0]   low_hint_q;
	logic [AddrW-1:0]  hint_word_q;
	logic [ValW-1:0]   hint_base_q;
	logic              done_q;
	dna_rsp_t          rsp_q;

	logic [ValW-1:0]   unit_ref;
	logic [ValW-1:0]   unit_base;
	dna_scan_flags_t   flags;
	logic [OffW-1:0]   unit_off;
	logic [OffW-1:0]   found_off;

	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr;
	logic [W-1:0]      mem_wdata;
	logic [AddrW-1:0]  mem_raddr;
	logic [W-1:0]      mem_rdata;
	logic [W-1:0]      bit_sel;
	logic              in_range;

	assign unit_ref  = (state_q == S_SCAN) ? high_mark_q : num_q;
	assign unit_base = (state_q == S_SCAN) ? chk_base_s1 : base_q;

	dna_word_scan #(
		.W     (W),
		.VAL_W (ValW)
	) u_scan (
		.ref_val   (unit_ref),
		.base      (unit_base),
		.word      (mem_rdata),
		.flags     (flags),
		.offset    (unit_off),
		.found_off (found_off)
	);

	assign bit_sel   = W'(1) << tgt_off_q;
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_RMW_WR);
	assign mem_waddr = (state_q == S_CLEAR) ? word_q : tgt_word_q;
	assign mem_raddr = (state_q == S_SCAN) ? word_q : tgt_word_q;

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_wdata = '0;
		end else if (op_q == DNA_MODE_FREE) begin
			mem_wdata = mem_rdata & ~bit_sel;
		end else begin
			mem_wdata = mem_rdata | bit_sel;
		end
	end

	dna_map_ram #(
		.WORDS (NUM_WORDS),
		.WIDTH (W)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_range = (32'(req.fd_number) < 32'(NUM_IDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			op_q        <= DNA_MODE_GET;
			mark_q      <= 1'b0;
			num_q       <= '0;
			word_q      <= '0;
			base_q      <= '0;
			chk_vld_s1  <= 1'b0;
			chk_word_s1 <= '0;
			chk_base_s1 <= '0;
			tgt_word_q  <= '0;
			tgt_base_q  <= '0;
			tgt_off_q   <= '0;
			tgt_id_q    <= '0;
			high_mark_q <= '0;
			hm_word_q   <= '0;
			hm_off_q    <= '0;
			low_hint_q  <= '0;
			hint_word_q <= '0;
			hint_base_q <= '0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (word_q == LastWord) begin
						state_q <= S_IDLE;
					end else begin
						word_q <= word_q + AddrW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= req.mode;
						num_q  <= ValW'(req.fd_number);
						mark_q <= 1'b0;
						case (req.mode)
							DNA_MODE_GET: begin
								word_q     <= hint_word_q;
								base_q     <= hint_base_q;
								chk_vld_s1 <= 1'b0;
								state_q    <= (hint_base_q >= high_mark_q) ? S_MARK : S_SCAN;
							end
							DNA_MODE_CLAIM, DNA_MODE_FREE: begin
								if (in_range) begin
									word_q  <= '0;
									base_q  <= '0;
									state_q <= S_LOCATE;
								end else begin
									rsp_q.granted_number <= req.fd_number;
									rsp_q.status         <= DNA_ST_RANGE;
									done_q               <= 1'b1;
								end
							end
							default: begin
								rsp_q.granted_number <= req.fd_number;
								rsp_q.status         <= DNA_ST_RANGE;
								done_q               <= 1'b1;
							end
						endcase
					end
				end
				S_LOCATE: begin
					if (flags.hit) begin
						tgt_word_q <= word_q;
						tgt_base_q <= base_q;
						tgt_off_q  <= unit_off;
						tgt_id_q   <= num_q;
						state_q    <= S_RMW_RD;
					end else begin
						word_q <= word_q + AddrW'(1);
						base_q <= base_q + WordStep;
					end
				end
				S_SCAN: begin
					if (base_q < high_mark_q) begin
						chk_vld_s1  <= 1'b1;
						chk_word_s1 <= word_q;
						chk_base_s1 <= base_q;
						word_q      <= word_q + AddrW'(1);
						base_q      <= base_q + WordStep;
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						if (flags.found) begin
							tgt_word_q <= chk_word_s1;
							tgt_base_q <= chk_base_s1;
							tgt_off_q  <= found_off;
							tgt_id_q   <= chk_base_s1 + ValW'(found_off);
							state_q    <= S_RMW_RD;
						end else if (flags.last) begin
							state_q <= S_MARK;
						end
					end
				end
				S_MARK: begin
					if (high_mark_q == NumIds) begin
						rsp_q.granted_number <= '0;
						rsp_q.status         <= DNA_ST_FULL;
						done_q               <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						mark_q     <= 1'b1;
						tgt_word_q <= hm_word_q;
						tgt_off_q  <= hm_off_q;
						tgt_id_q   <= high_mark_q;
						state_q    <= S_RMW_RD;
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					rsp_q.granted_number <= 8'(tgt_id_q);
					rsp_q.status         <= DNA_ST_OK;
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
					case (op_q)
						DNA_MODE_GET: begin
							if (mark_q) begin
								high_mark_q <= high_mark_q + ValW'(1);
								if (hm_off_q == LastOff) begin
									hm_off_q  <= '0;
									hm_word_q <= hm_word_q + AddrW'(1);
								end else begin
									hm_off_q <= hm_off_q + OffW'(1);
								end
							end else begin
								low_hint_q  <= tgt_id_q;
								hint_word_q <= tgt_word_q;
								hint_base_q <= tgt_base_q;
							end
						end
						DNA_MODE_CLAIM: begin
							if (num_q >= high_mark_q) begin
								high_mark_q <= num_q + ValW'(1);
								if (tgt_off_q == LastOff) begin
									hm_off_q  <= '0;
									hm_word_q <= tgt_word_q + AddrW'(1);
								end else begin
									hm_off_q  <= tgt_off_q + OffW'(1);
									hm_word_q <= tgt_word_q;
								end
							end
						end
						DNA_MODE_FREE: begin
							if (num_q < low_hint_q) begin
								low_hint_q  <= num_q;
								hint_word_q <= tgt_word_q;
								hint_base_q <= tgt_base_q;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`DNA_ASSERT_IMPL(a_hint_below_mark, 1'b1, low_hint_q <= high_mark_q, "hint lies above the high mark")
	`DNA_ASSERT_IMPL(a_mark_in_range, 1'b1, high_mark_q <= NumIds, "high mark beyond the number space")
	`DNA_ASSERT_NEXT(a_write_gives_ok, state_q == S_RMW_WR, done && (rsp.status == DNA_ST_OK), "bitmap write without an ok result")
	`DNA_ASSERT_NEXT(a_get_goes_busy, start && !busy && (req.mode == DNA_MODE_GET), busy && !done, "get finished without a search")

endmodule

FILE: rtl/dna_map_ram.sv
// Word-wide memory holding the used-number bitmap, with a registered read port.
module dna_map_ram #(
	parameter int WORDS = 16,
	parameter int WIDTH = 16,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/dna_word_scan.sv
// Shared compare unit: offset of a number within a word and lowest free bit below a limit.
module dna_word_scan import dna_pkg::*; #(
	parameter int W     = DNA_SCAN_WORD_BITS,
	parameter int VAL_W = 9,
	localparam int OFF_W = (W > 1) ? $clog2(W) : 1
) (
	input  logic [VAL_W-1:0] ref_val,
	input  logic [VAL_W-1:0] base,
	input  logic [W-1:0]     word,
	output dna_scan_flags_t  flags,
	output logic [OFF_W-1:0] offset,
	output logic [OFF_W-1:0] found_off
);

	localparam logic signed [VAL_W:0] WordS = (VAL_W+1)'(W);

	logic signed [VAL_W:0] diff;
	logic [W-1:0]          in_rng;
	logic [W-1:0]          free_v;

	assign diff = $signed({1'b0, ref_val}) - $signed({1'b0, base});

	always_comb begin
		for (int j = 0; j < W; j++) begin
			in_rng[j] = (diff > $signed((VAL_W+1)'(j)));
		end
		free_v = ~word & in_rng;
		found_off = '0;
		for (int j = W - 1; j >= 0; j--) begin
			if (free_v[j]) begin
				found_off = OFF_W'(j);
			end
		end
	end

	assign flags.hit   = (diff >= $signed((VAL_W+1)'(0))) && (diff < WordS);
	assign flags.last  = (diff <= WordS);
	assign flags.found = |free_v;
	assign offset      = diff[OFF_W-1:0];

endmodule
